[hw/rtl/first_fit_block_allocator_defines.svh]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines.svh
// Assertion macros used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  // Pool size after reset
  localparam logic [31:0] POOL_SIZE_RESET = 32'd65536;

  // Command beat
  typedef struct packed {
    logic        func;
    logic [31:0] request_bytes;
    logic [31:0] block_offset;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [31:0] granted_offset;
    logic [1:0]  status;
  } rsp_t;

  // Verdict on one table row
  typedef struct packed {
    logic        reuse_hit;
    logic        split_hit;
    logic        match_hit;
    logic [31:0] slack;
  } eval_t;

endpackage

[hw/rtl/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte pool, block table held in one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The table is walked
// one row per cycle through the RAM's single registered read port: row 0 is read
// while idle, each row in use is then checked in turn, and a split ends with an
// append step and a bump allocation with a bump step. The result beat shows on
// rsp for one cycle with done high and cannot be held off; a new command may
// be started in that same cycle. The pool size register is written through
// cfg_valid/cfg_ready only while busy is low. The table needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffba_pkg::cmd_t cmd,
  output logic           done,
  output ffba_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int LW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int RW = OFFSET_BITS + 65;

  localparam logic [LW-1:0] OFF_MASK = LW'({OFFSET_BITS{1'b1}});

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_BUMP   = 3'd3;

  // Row layout: {freed, used, capacity, start}
  function automatic logic [RW-1:0] pack_row(input logic [OFFSET_BITS-1:0] s,
                                             input logic [31:0] c,
                                             input logic [31:0] u,
                                             input logic f);
    return {f, u, c, s};
  endfunction

  // Pool limit, clipped so every offset stays representable
  function automatic logic [LW-1:0] clip_limit(input logic [31:0] v);
    return (LW'(v) > OFF_MASK) ? OFF_MASK : LW'(v);
  endfunction

  logic [2:0]             state;
  logic                   func_q;
  logic [31:0]            req_q;
  logic [31:0]            off_q;
  logic [IW-1:0]          scan_idx;
  logic [CW-1:0]          block_count;
  logic [OFFSET_BITS-1:0] bump_offset;
  logic [LW-1:0]          pool_limit;
  logic [OFFSET_BITS-1:0] nstart_q;
  logic [31:0]            slack_q;

  logic                   we;
  logic [IW-1:0]          waddr;
  logic [RW-1:0]          wdata;
  logic [IW-1:0]          raddr;
  logic [RW-1:0]          rdata;

  logic [OFFSET_BITS-1:0] rd_start;
  logic [31:0]            rd_cap;
  logic [31:0]            rd_used;
  logic                   rd_freed;
  ffba_pkg::eval_t        ev;
  logic [OFFSET_BITS-1:0] split_start;

  logic                   table_full;
  logic                   scan_last;
  logic                   hit_reuse;
  logic                   hit_split;
  logic                   hit_free;
  logic                   bump_fit;
  logic [LW-1:0]          bump_lw;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Table storage
  ffba_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_start = rdata[OFFSET_BITS-1:0];
  assign rd_cap   = rdata[OFFSET_BITS +: 32];
  assign rd_used  = rdata[OFFSET_BITS+32 +: 32];
  assign rd_freed = rdata[RW-1];

  // Row checker, used once per scan cycle
  ffba_row_eval #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_eval (
    .row_start   (rd_start),
    .row_cap     (rd_cap),
    .row_used    (rd_used),
    .row_freed   (rd_freed),
    .req         (req_q),
    .off         (off_q),
    .ev          (ev),
    .split_start (split_start)
  );

  // Read one row ahead of the one being checked
  assign raddr = (state == S_SCAN) ? (scan_idx + IW'(1)) : '0;

  // Scan decisions
  assign table_full = (block_count == CW'(MAX_BLOCKS));
  assign scan_last  = ((CW'(scan_idx) + CW'(1)) == block_count);
  assign hit_reuse  = (state == S_SCAN) && (func_q == ffba_pkg::FUNC_ALLOC) && ev.reuse_hit;
  assign hit_split  = (state == S_SCAN) && (func_q == ffba_pkg::FUNC_ALLOC) &&
                      !ev.reuse_hit && ev.split_hit;
  assign hit_free   = (state == S_SCAN) && (func_q == ffba_pkg::FUNC_FREE) && ev.match_hit;

  // Bump fit check against the clipped limit
  assign bump_lw  = LW'(bump_offset);
  assign bump_fit = !(bump_lw > pool_limit) && !(LW'(req_q) > (pool_limit - bump_lw));

  // Table write port
  always_comb begin
    we    = 1'b0;
    waddr = scan_idx;
    wdata = pack_row(rd_start, rd_cap, rd_used, rd_freed);
    if (hit_reuse) begin
      we    = 1'b1;
      wdata = pack_row(rd_start, rd_cap, req_q, 1'b0);
    end else if (hit_split && !table_full) begin
      we    = 1'b1;
      wdata = pack_row(rd_start, rd_used, rd_used, rd_freed);
    end else if (hit_free) begin
      we    = 1'b1;
      wdata = pack_row(rd_start, rd_cap, 32'd0, 1'b1);
    end else if (state == S_APPEND) begin
      we    = 1'b1;
      waddr = block_count[IW-1:0];
      wdata = pack_row(nstart_q, slack_q, req_q, 1'b0);
    end else if ((state == S_BUMP) && bump_fit && !table_full) begin
      we    = 1'b1;
      waddr = block_count[IW-1:0];
      wdata = pack_row(bump_offset, req_q, req_q, 1'b0);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      block_count <= '0;
      bump_offset <= '0;
      pool_limit  <= clip_limit(ffba_pkg::POOL_SIZE_RESET);
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            pool_limit <= clip_limit(cfg_data);
          end
          if (start) begin
            func_q   <= cmd.func;
            req_q    <= cmd.request_bytes;
            off_q    <= cmd.block_offset;
            scan_idx <= '0;
            if (block_count != '0) begin
              state <= S_SCAN;
            end else if (cmd.func == ffba_pkg::FUNC_ALLOC) begin
              state <= S_BUMP;
            end else begin
              done               <= 1'b1;
              rsp.granted_offset <= 32'd0;
              rsp.status         <= ffba_pkg::ST_NOT_FOUND;
            end
          end
        end
        S_SCAN: begin
          if (hit_reuse) begin
            done               <= 1'b1;
            rsp.granted_offset <= 32'(rd_start);
            rsp.status         <= ffba_pkg::ST_OK;
            state              <= S_IDLE;
          end else if (hit_split) begin
            if (table_full) begin
              done               <= 1'b1;
              rsp.granted_offset <= 32'd0;
              rsp.status         <= ffba_pkg::ST_TABLE_FULL;
              state              <= S_IDLE;
            end else begin
              nstart_q <= split_start;
              slack_q  <= ev.slack;
              state    <= S_APPEND;
            end
          end else if (hit_free) begin
            done               <= 1'b1;
            rsp.granted_offset <= 32'd0;
            rsp.status         <= ffba_pkg::ST_OK;
            state              <= S_IDLE;
          end else if (scan_last) begin
            if (func_q == ffba_pkg::FUNC_ALLOC) begin
              state <= S_BUMP;
            end else begin
              done               <= 1'b1;
              rsp.granted_offset <= 32'd0;
              rsp.status         <= ffba_pkg::ST_NOT_FOUND;
              state              <= S_IDLE;
            end
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_APPEND: begin
          block_count        <= block_count + CW'(1);
          done               <= 1'b1;
          rsp.granted_offset <= 32'(nstart_q);
          rsp.status         <= ffba_pkg::ST_OK;
          state              <= S_IDLE;
        end
        S_BUMP: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (!bump_fit) begin
            rsp.granted_offset <= 32'd0;
            rsp.status         <= ffba_pkg::ST_NO_SPACE;
          end else if (table_full) begin
            rsp.granted_offset <= 32'd0;
            rsp.status         <= ffba_pkg::ST_TABLE_FULL;
          end else begin
            block_count        <= block_count + CW'(1);
            bump_offset        <= OFFSET_BITS'(bump_lw + LW'(req_q));
            rsp.granted_offset <= 32'(bump_offset);
            rsp.status         <= ffba_pkg::ST_OK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ffba_row_eval.sv]
// ----------------------------------------------------------------------------
// ffba_row_eval
// Shared row evaluator: checks one table row against the pending command.
// ----------------------------------------------------------------------------
module ffba_row_eval #(
  parameter int OFFSET_BITS = 32
) (
  input  logic [OFFSET_BITS-1:0] row_start,
  input  logic [31:0]            row_cap,
  input  logic [31:0]            row_used,
  input  logic                   row_freed,
  input  logic [31:0]            req,
  input  logic [31:0]            off,
  output ffba_pkg::eval_t        ev,
  output logic [OFFSET_BITS-1:0] split_start
);

  localparam int LW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  logic [31:0] slack;

  // Unused room at the tail of the row, never negative
  assign slack = (row_cap >= row_used) ? (row_cap - row_used) : 32'd0;

  always_comb begin
    ev.reuse_hit = row_freed && (row_cap >= req);
    ev.split_hit = (slack >= req);
    ev.match_hit = (LW'(row_start) == LW'(off));
    ev.slack     = slack;
  end

  // New row starts right after the bytes in use
  assign split_start = OFFSET_BITS'(LW'(row_start) + LW'(row_used));

endmodule

[hw/rtl/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input ffba_pkg::rsp_t rsp,
  input logic           cfg_ready
);

  logic fail_beat;

  // Result beat that carries an error status
  assign fail_beat = done && (rsp.status != ffba_pkg::ST_OK);

  // A result beat comes only once the sequencer is back at rest
  `FFBA_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")

  // An accepted command either starts work or answers next cycle
  `FFBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "command dropped")

  // Work always ends in a result beat
  `FFBA_ASSERT_NOW(a_end_has_beat, $fell(busy), done, "work ended without result")

  // A failed request never hands out an offset
  `FFBA_ASSERT_NOW(a_fail_zero, fail_beat, rsp.granted_offset == 32'd0, "offset on failure")

  // Config is open exactly when no command is in flight
  `FFBA_ASSERT_NOW(a_cfg_idle, 1'b1, cfg_ready == !busy, "config open while busy")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
